### hdl/sspwm_pkg.sv
// ----------------------------------------------------------------------------
// sspwm_pkg
// Shared widths, constants and the quarter-wave sine generator used to
// build the sine table at elaboration.
// ----------------------------------------------------------------------------
package sspwm_pkg;

	localparam int unsigned CarrierW = 16;
	localparam int unsigned BaseStepW = 27;
	localparam int unsigned DepthW = 17;
	localparam int unsigned SampleW = 13;
	localparam int unsigned SineW = 16;
	localparam int unsigned AbsW = 15;
	localparam int unsigned ProdW = AbsW + DepthW;
	localparam int unsigned MagW = 16;

	localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
	localparam logic [63:0] OneQ30 = 64'd1073741824;
	localparam logic signed [SampleW-1:0] PulsePos = 13'sd3276;
	localparam logic signed [SampleW-1:0] PulseNeg = -13'sd3276;
	localparam logic signed [SampleW-1:0] PulseOff = 13'sd0;
	localparam logic [MagW-1:0] MagMax = 16'hFFFF;

	typedef logic signed [SineW-1:0] sine_t;

	function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] p;
		p = a * b;
		return p >> 30;
	endfunction

	// sin((pi/2) * r / 2**depth_log2) in Q15, Taylor series in Q30
	function automatic sine_t quarter_sine(input logic [63:0] r, input int unsigned depth_log2);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		x = (HalfPiQ30 * r) >> depth_log2;
		x2 = qmul(x, x);
		t = OneQ30 - x2 / 64'd110;
		t = OneQ30 - qmul(x2 / 64'd72, t);
		t = OneQ30 - qmul(x2 / 64'd42, t);
		t = OneQ30 - qmul(x2 / 64'd20, t);
		t = OneQ30 - qmul(x2 / 64'd6, t);
		s = qmul(x, t);
		s = (s + 64'd16384) >> 15;
		if (s > 64'd32767) begin
			s = 64'd32767;
		end
		return sine_t'(s[SineW-1:0]);
	endfunction

endpackage

### hdl/sspwm_tick_if.sv
// ----------------------------------------------------------------------------
// sspwm_tick_if
// Sample tick channel: carrier step, fundamental step and modulation depth.
// ----------------------------------------------------------------------------
interface sspwm_tick_if;
	logic valid;
	logic ready;
	logic [15:0] carrier_step;
	logic [26:0] base_step;
	logic [16:0] modulation_depth;

	modport source (output valid, output carrier_step, output base_step,
		output modulation_depth, input ready);
	modport sink (input valid, input carrier_step, input base_step,
		input modulation_depth, output ready);
endinterface

### hdl/sspwm_pwm_if.sv
// ----------------------------------------------------------------------------
// sspwm_pwm_if
// PWM sample channel: one three-level sample per item.
// ----------------------------------------------------------------------------
interface sspwm_pwm_if;
	logic valid;
	logic ready;
	logic signed [12:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

### hdl/sine_saw_pwm_three_level.sv
// ----------------------------------------------------------------------------
// sine_saw_pwm_three_level
// Three-level sinusoidal PWM with a sawtooth carrier.
// ----------------------------------------------------------------------------
// Usage:
//   tick: one item per sample, carrying carrier_step, base_step and
//   modulation_depth. pwm: one sample item (+3276, 0 or -3276) per tick.
//   Each accepted tick advances the phase and saw accumulators at once; the
//   sine is read at the phase held before that tick.
//   Pipeline: an accepted tick passes the table read, product, scale and
//   saturate, and compare into output register stages in that order.
//   Throughput: one tick per cycle while tick ready is high; no stage holds
//   more than one table read port access or one 15x17 multiply.
//   Reset (arst_n low) clears both accumulators and all item valids; tick
//   ready is high after reset. The sine table is a constant ROM and needs
//   no fill.
//   Stall: while pwm is held, one more result goes to a skid entry, then
//   tick ready drops the next cycle and the whole pipeline holds until the
//   skid entry drains. tick ready is a register output.
// ----------------------------------------------------------------------------
module sine_saw_pwm_three_level #(
	parameter int unsigned PHASE_BITS = 28,
	parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	sspwm_tick_if.sink  tick,
	sspwm_pwm_if.source pwm
);
	import sspwm_pkg::*;

	localparam int unsigned AddrW = $clog2(SINE_TABLE_DEPTH);
	localparam int unsigned SumW = 33;

	logic en;
	logic accept;
	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] phase_next;
	logic [SumW-1:0] phase_sum;
	logic [CarrierW-1:0] saw_q;
	logic [CarrierW-1:0] saw_next;

	logic valid_s1, valid_s2, valid_s3;
	logic [CarrierW-1:0] saw_s1, saw_s2, saw_s3;
	logic [DepthW-1:0] depth_s1;
	sine_t sine_s1;
	logic [MagW-1:0] mag_s3;
	logic pos_s3;
	logic signed [SampleW-1:0] sample_d;

	assign tick.ready = en;
	assign accept = tick.valid && en;

	assign phase_sum = SumW'(phase_q) + SumW'(tick.base_step);
	assign phase_next = phase_sum[PHASE_BITS-1:0];
	assign saw_next = saw_q + tick.carrier_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			saw_q <= '0;
		end else if (accept) begin
			phase_q <= phase_next;
			saw_q <= saw_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= tick.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			saw_s1 <= saw_next;
			depth_s1 <= tick.modulation_depth;
			saw_s2 <= saw_s1;
			saw_s3 <= saw_s2;
		end
	end

	sspwm_sine_rom #(
		.Depth (SINE_TABLE_DEPTH),
		.AddrW (AddrW)
	) u_rom (
		.clk  (clk),
		.en   (en),
		.addr (phase_q[PHASE_BITS-1 -: AddrW]),
		.data (sine_s1)
	);

	sspwm_amp u_amp (
		.clk      (clk),
		.en       (en),
		.sine     (sine_s1),
		.depth    (depth_s1),
		.mag      (mag_s3),
		.positive (pos_s3)
	);

	always_comb begin
		sample_d = PulseOff;
		if (saw_s3 < mag_s3) begin
			sample_d = pos_s3 ? PulsePos : PulseNeg;
		end
	end

	sspwm_out_buf u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (en && valid_s3),
		.data   (sample_d),
		.ready  (en),
		.pwm    (pwm)
	);

`ifndef SYNTH
	a_phase_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(phase_q) && $stable(saw_q))
		else $error("accumulator moved without an accepted item");
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted item missing from first stage");
	a_sample_levels: assert property (@(posedge clk) disable iff (!arst_n)
		pwm.valid |-> (pwm.sample == PulseOff || pwm.sample == PulsePos ||
			pwm.sample == PulseNeg))
		else $error("sample outside the three levels");
`endif

endmodule

### hdl/sspwm_sine_rom.sv
// ----------------------------------------------------------------------------
// sspwm_sine_rom
// One-period Q15 sine table, filled at elaboration, registered read port.
// ----------------------------------------------------------------------------
module sspwm_sine_rom #(
	parameter int unsigned Depth = 1024,
	parameter int unsigned AddrW = $clog2(Depth)
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [AddrW-1:0]          addr,
	output sspwm_pkg::sine_t          data
);
	import sspwm_pkg::*;

	typedef sine_t rom_t [Depth];

	function automatic rom_t build_rom();
		rom_t tbl;
		logic [63:0] u;
		logic [63:0] quad;
		logic [63:0] rem;
		for (int unsigned i = 0; i < Depth; i++) begin
			u = 64'(i) << 2;
			quad = u >> AddrW;
			rem = u & 64'(Depth - 1);
			case (quad)
				64'd0: tbl[i] = quarter_sine(rem, AddrW);
				64'd1: tbl[i] = quarter_sine(64'(Depth) - rem, AddrW);
				64'd2: tbl[i] = -quarter_sine(rem, AddrW);
				default: tbl[i] = -quarter_sine(64'(Depth) - rem, AddrW);
			endcase
		end
		return tbl;
	endfunction

	localparam rom_t Rom = build_rom();

	always_ff @(posedge clk) begin
		if (en) begin
			data <= Rom[addr];
		end
	end

endmodule

### hdl/sspwm_amp.sv
// ----------------------------------------------------------------------------
// sspwm_amp
// Two-stage amplitude path: |sine| * depth, then * 65535 >> 31 with
// saturation to 16 bits.
// ----------------------------------------------------------------------------
module sspwm_amp (
	input  logic                           clk,
	input  logic                           en,
	input  sspwm_pkg::sine_t               sine,
	input  logic [sspwm_pkg::DepthW-1:0]   depth,
	output logic [sspwm_pkg::MagW-1:0]     mag,
	output logic                           positive
);
	import sspwm_pkg::*;

	logic [AbsW-1:0] abs_val;
	logic [ProdW-1:0] prod_s2;
	logic pos_s2;
	logic [ProdW+15:0] scaled;
	logic [16:0] shifted;

	assign abs_val = sine[SineW-1] ? AbsW'(-sine) : AbsW'(sine);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= ProdW'(abs_val) * ProdW'(depth);
			pos_s2 <= !sine[SineW-1] && (sine != '0);
		end
	end

	// x * 65535 = (x << 16) - x
	assign scaled = {prod_s2, 16'd0} - {16'd0, prod_s2};
	assign shifted = scaled[ProdW+15:31];

	always_ff @(posedge clk) begin
		if (en) begin
			mag <= (shifted > 17'(MagMax)) ? MagMax : shifted[MagW-1:0];
			positive <= pos_s2;
		end
	end

endmodule

### hdl/sspwm_out_buf.sv
// ----------------------------------------------------------------------------
// sspwm_out_buf
// Output register with one skid entry; ready to the pipeline is registered.
// ----------------------------------------------------------------------------
module sspwm_out_buf (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  logic signed [sspwm_pkg::SampleW-1:0] data,
	output logic                                 ready,
	sspwm_pwm_if.source                          pwm
);
	import sspwm_pkg::*;

	logic out_valid_q;
	logic skid_valid_q;
	logic signed [SampleW-1:0] out_data_q;
	logic signed [SampleW-1:0] skid_data_q;
	logic slot_free;

	assign slot_free = !out_valid_q || pwm.ready;
	assign ready = !skid_valid_q;
	assign pwm.valid = out_valid_q;
	assign pwm.sample = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (slot_free) begin
			if (skid_valid_q) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (push) begin
				out_data_q <= data;
			end
		end else if (push) begin
			skid_data_q <= data;
		end
	end

`ifndef SYNTH
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without output item");
	a_push_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_valid_q)
		else $error("item pushed while skid entry full");
	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && pwm.ready) |=> (out_valid_q && !skid_valid_q))
		else $error("skid entry not moved to output");
`endif

endmodule
